// File: rtl/bdp_pkg.sv
// Shared types and constants of the byte stream delta patcher.
package bdp_pkg;

  // Default width of data and patch positions
  localparam int POSITION_BITS_DEF = 64;

  // Varint accumulator width and overflow guard (top seven bits)
  localparam int VARINT_W = 64;
  localparam logic [VARINT_W-1:0] VARINT_TOP = 64'hFE00_0000_0000_0000;

  // Leading varint byte that ends the patch
  localparam logic [7:0] BYTE_PATCH_END = 8'h80;

  // Continuation flag position within a varint byte
  localparam int CONT_BIT = 7;

  // Item kinds carried on the input tuser
  typedef enum logic [1:0] {
    OP_PATCH = 2'd0,
    OP_DATA  = 2'd1,
    OP_END   = 2'd2
  } op_t;

  // Varint decode phase
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_INSIDE = 2'd1,
    PH_REPL   = 2'd2
  } phase_t;

  // Decoder outcome for one patch byte
  typedef struct packed {
    logic [VARINT_W-1:0] acc_nxt;
    phase_t              phase_nxt;
    logic                cand_ld;
    logic                end_set;
    logic                commit;
  } vint_res_t;

  // One result word
  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       replaced;
    logic       want_diff;
    logic       patch_ended;
  } step_res_t;

endpackage

// File: rtl/byte_stream_delta_patcher.sv
// Path: an accepted word is captured in the input register, processed into the result
//   register when that register is empty or taken, and offered on the output from then on.
// Throughput: one word per cycle unless out_tready stalls; the input and result registers
//   each hold one word, and the whole update (65-bit add and compare) sits between them.
// Reset: synchronous, active low; clears positions, decoder phase, pending entries and
//   the patch end flag, and empties both registers.
// Top level of the byte stream delta patcher.
module byte_stream_delta_patcher
  import bdp_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] value
  input  logic [1:0]  in_tuser,   // [1:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [8] want_diff, [9] patch_ended
  output logic [1:0]  out_tuser   // [0] out_valid, [1] replaced
);

  logic       in_vld_r, in_vld_nxt;
  logic [1:0] op_r;
  logic [7:0] val_r;
  logic       out_vld_r, out_vld_nxt;
  step_res_t  res_r;
  step_res_t  res_w;
  logic       adv;
  logic       fire;

  // Advance the result register when empty or taken
  assign adv       = !out_vld_r || out_tready;
  assign fire      = in_vld_r && adv;
  assign in_tready = !in_vld_r || adv;

  assign in_vld_nxt  = in_tready ? in_tvalid : in_vld_r;
  assign out_vld_nxt = adv ? in_vld_r : out_vld_r;

  bdp_step #(
    .POSITION_BITS(POSITION_BITS)
  ) u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .op    (op_r),
    .value (val_r),
    .res   (res_w)
  );

  // Hold valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Capture the input word and the result word
  always_ff @(posedge clk) begin
    if (in_tready) begin
      op_r  <= in_tuser;
      val_r <= in_tdata;
    end
    if (fire) begin
      res_r <= res_w;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'b0, res_r.patch_ended, res_r.want_diff, res_r.out_byte};
  assign out_tuser  = {res_r.replaced, res_r.out_valid};

endmodule

// File: rtl/bdp_varint.sv
// Varint delta decoder: next accumulator, phase and candidate position for one patch byte.
module bdp_varint
  import bdp_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                     en,
  input  logic [7:0]               pbyte,
  input  phase_t                   phase,
  input  logic [VARINT_W-1:0]      acc,
  input  logic [POSITION_BITS-1:0] running,
  output vint_res_t                res,
  output logic [POSITION_BITS-1:0] cand
);

  localparam int SW = VARINT_W + 1;
  localparam int PAD = SW - POSITION_BITS;
  localparam logic [SW-1:0] MASK_EXT = {{PAD{1'b0}}, {POSITION_BITS{1'b1}}};

  logic [VARINT_W-1:0] n_w;
  logic [SW-1:0]       sum_w;
  logic                bad_w;
  logic                fin_w;

  // Value of the varint if this byte completes it
  assign n_w = (phase == PH_FIRST) ? {{(VARINT_W-8){1'b0}}, pbyte}
                                   : {acc[VARINT_W-8:0], pbyte[6:0]};

  // Candidate position and range check in one widened add
  assign sum_w = {1'b0, n_w} + {{PAD{1'b0}}, running};
  assign bad_w = (n_w == '1) || (sum_w >= MASK_EXT);
  assign cand  = sum_w[POSITION_BITS-1:0];

  always_comb begin
    res.acc_nxt   = acc;
    res.phase_nxt = phase;
    res.cand_ld   = 1'b0;
    res.end_set   = 1'b0;
    res.commit    = 1'b0;
    fin_w         = 1'b0;
    if (en) begin
      unique case (phase)
        PH_FIRST: begin
          if (pbyte == BYTE_PATCH_END) begin
            res.end_set = 1'b1;
          end else if (pbyte[CONT_BIT]) begin
            res.acc_nxt   = {{(VARINT_W-7){1'b0}}, pbyte[6:0]};
            res.phase_nxt = PH_INSIDE;
          end else begin
            fin_w = 1'b1;
          end
        end
        PH_INSIDE: begin
          if ((acc & VARINT_TOP) != '0) begin
            res.end_set = 1'b1;
          end else if (!pbyte[CONT_BIT]) begin
            fin_w = 1'b1;
          end else begin
            res.acc_nxt = n_w;
          end
        end
        PH_REPL: begin
          res.commit    = 1'b1;
          res.phase_nxt = PH_FIRST;
        end
        default: ;
      endcase
      // Close the varint: take the entry or end the patch on overflow
      if (fin_w) begin
        if (bad_w) begin
          res.end_set = 1'b1;
        end else begin
          res.acc_nxt   = '0;
          res.cand_ld   = 1'b1;
          res.phase_nxt = PH_REPL;
        end
      end
      if (res.end_set) begin
        res.acc_nxt   = '0;
        res.phase_nxt = PH_FIRST;
      end
    end
  end

endmodule

// File: rtl/bdp_step.sv
// Patcher state and per-word update: positions, pending entries and the result word.
module bdp_step
  import bdp_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [1:0] op,
  input  logic [7:0] value,
  output step_res_t  res
);

  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [VARINT_W-1:0]      acc_r, acc_nxt;
  phase_t                   phase_r, phase_nxt;
  logic [POSITION_BITS-1:0] cand_r, cand_nxt;
  logic [POSITION_BITS-1:0] running_r, running_nxt;
  logic [7:0]               ahead_byte_r, ahead_byte_nxt;
  logic                     ahead_valid_r, ahead_valid_nxt;
  logic [7:0]               here_byte_r, here_byte_nxt;
  logic                     here_valid_r, here_valid_nxt;
  logic                     done_r, done_nxt;

  logic                     en_patch;
  vint_res_t                vr;
  logic [POSITION_BITS-1:0] cand_w;
  logic [POSITION_BITS-1:0] pos_inc;

  // Patch bytes count only while the patch is live and nothing waits ahead
  assign en_patch = fire && (op == OP_PATCH) && !done_r && !ahead_valid_r;

  bdp_varint #(
    .POSITION_BITS(POSITION_BITS)
  ) u_varint (
    .en      (en_patch),
    .pbyte   (value),
    .phase   (phase_r),
    .acc     (acc_r),
    .running (running_r),
    .res     (vr),
    .cand    (cand_w)
  );

  // Saturating data position advance
  assign pos_inc = (pos_r != '1) ? pos_r + 1'b1 : pos_r;

  // Next state and result word
  always_comb begin
    pos_nxt         = pos_r;
    acc_nxt         = acc_r;
    phase_nxt       = phase_r;
    cand_nxt        = cand_r;
    running_nxt     = running_r;
    ahead_byte_nxt  = ahead_byte_r;
    ahead_valid_nxt = ahead_valid_r;
    here_byte_nxt   = here_byte_r;
    here_valid_nxt  = here_valid_r;
    done_nxt        = done_r;
    res.out_valid   = 1'b0;
    res.out_byte    = '0;
    res.replaced    = 1'b0;
    if (fire) begin
      unique case (op)
        OP_PATCH: begin
          acc_nxt   = vr.acc_nxt;
          phase_nxt = vr.phase_nxt;
          if (vr.cand_ld) begin
            cand_nxt = cand_w;
          end
          if (vr.end_set) begin
            done_nxt = 1'b1;
          end
          // File the finished entry here, ahead, or drop it if already passed
          if (vr.commit) begin
            running_nxt = cand_r;
            if (cand_r == pos_r) begin
              here_byte_nxt  = value;
              here_valid_nxt = 1'b1;
            end else if (cand_r > pos_r) begin
              ahead_byte_nxt  = value;
              ahead_valid_nxt = 1'b1;
            end
          end
        end
        OP_DATA: begin
          res.out_valid  = 1'b1;
          res.out_byte   = here_valid_r ? here_byte_r : value;
          res.replaced   = here_valid_r;
          here_valid_nxt = 1'b0;
          pos_nxt        = pos_inc;
          // Promote the waiting entry once the data position reaches it
          if (ahead_valid_r && (running_r == pos_inc)) begin
            here_byte_nxt   = ahead_byte_r;
            here_valid_nxt  = 1'b1;
            ahead_valid_nxt = 1'b0;
          end
        end
        OP_END: begin
          done_nxt  = 1'b1;
          phase_nxt = PH_FIRST;
          acc_nxt   = '0;
        end
        default: ;
      endcase
    end
    res.want_diff   = !done_nxt && !ahead_valid_nxt;
    res.patch_ended = done_nxt;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= '0;
      acc_r         <= '0;
      phase_r       <= PH_FIRST;
      running_r     <= '0;
      ahead_valid_r <= 1'b0;
      here_valid_r  <= 1'b0;
      done_r        <= 1'b0;
    end else begin
      pos_r         <= pos_nxt;
      acc_r         <= acc_nxt;
      phase_r       <= phase_nxt;
      running_r     <= running_nxt;
      ahead_valid_r <= ahead_valid_nxt;
      here_valid_r  <= here_valid_nxt;
      done_r        <= done_nxt;
    end
  end

  // Entry payload
  always_ff @(posedge clk) begin
    cand_r       <= cand_nxt;
    ahead_byte_r <= ahead_byte_nxt;
    here_byte_r  <= here_byte_nxt;
  end

  // A waiting entry always lies beyond the data position
  a_ahead_beyond: assert property (@(posedge clk) disable iff (!rst_n)
    ahead_valid_r |-> (running_r > pos_r))
    else $error("entry waits ahead at or behind the data position");

  // No replacement byte is expected once the patch has ended
  a_repl_live: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_REPL) |-> !done_r)
    else $error("replacement pending after patch end");

  // Patch end is sticky until reset
  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> done_r)
    else $error("patch end flag cleared");

  // Accumulator is clear outside a multi-byte varint
  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_INSIDE) |-> (acc_r == '0))
    else $error("varint accumulator not clear between varints");

endmodule
